// ===== sv/ect_pkg.sv =====
// Shared types and constants for the expression character tokenizer.
// No dependencies; every other file of the block imports this package.
package ect_pkg;

   // Default longest lexeme length before the count saturates
   localparam int MaxLexemeLenDefault = 255;
   // Result queue depth; two words may enter per cycle
   localparam int RspDepth = 4;

   // Token kinds
   localparam logic [2:0] KIND_ID  = 3'd0;
   localparam logic [2:0] KIND_NUM = 3'd1;
   localparam logic [2:0] KIND_OP  = 3'd2;
   localparam logic [2:0] KIND_END = 3'd3;
   localparam logic [2:0] KIND_ERR = 3'd4;

   // Character codes
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;

   // Scanner modes, one-hot
   typedef enum logic [4:0] {
      MODE_IDLE  = 5'b00001,
      MODE_IDENT = 5'b00010,
      MODE_INT   = 5'b00100,
      MODE_FRAC  = 5'b01000,
      MODE_DOT   = 5'b10000
   } mode_type;

   // Input word
   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_input;
   } req_type;

   // Result word
   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] op_char;
      logic [7:0] lexeme_len;
      logic       last;
   } rsp_type;

   // Outcome of one scanner step
   typedef struct packed {
      logic [1:0] n_results;
      rsp_type    slot0;
      rsp_type    slot1;
      mode_type   mode;
      logic [7:0] count;
      logic       halt;
   } step_type;

endpackage

// ===== sv/ect_step.sv =====
// One scanner step: classify a character and work out the next mode, count and results.
// Depends on ect_pkg.
module ect_step
   import ect_pkg::*;
#(
   parameter int MAX_LEXEME_LEN = MaxLexemeLenDefault
) (
   input  req_type    item,
   input  mode_type   mode,
   input  logic [7:0] count,
   output step_type   step
);

   localparam int LenCapInt = (MAX_LEXEME_LEN < 255) ? MAX_LEXEME_LEN : 255;
   localparam logic [7:0] LEN_CAP = 8'(LenCapInt);

   logic       is_space, is_digit, is_alpha, is_op;
   logic [7:0] bumped;
   rsp_type    flush_rsp;
   rsp_type    id_rsp;
   logic       id_emit;
   logic       id_halt;
   mode_type   id_mode;
   logic [7:0] id_count;
   logic [2:0] flush_kind;

   // Classify the character
   always_comb begin
      is_space = (item.ch == CH_SPACE) || (item.ch inside {[CH_TAB:CH_CR]});
      is_digit = item.ch inside {[CH_0:CH_9]};
      is_alpha = item.ch inside {[CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z]};
      is_op    = item.ch inside {CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                 CH_PCT, CH_CARET, CH_LPAREN, CH_RPAREN};
      bumped   = (count < LEN_CAP) ? count + 8'd1 : count;
   end

   // Handle the character as if no token were pending
   always_comb begin
      id_mode  = MODE_IDLE;
      id_count = 8'd0;
      id_emit  = 1'b0;
      id_halt  = 1'b0;
      id_rsp   = '{token_kind: KIND_ERR, op_char: 8'd0, lexeme_len: 8'd1, last: 1'b0};
      if (is_space) begin
         id_mode = MODE_IDLE;
      end else if (is_alpha) begin
         id_mode  = MODE_IDENT;
         id_count = 8'd1;
      end else if (is_digit) begin
         id_mode  = MODE_INT;
         id_count = 8'd1;
      end else if (item.ch == CH_DOT) begin
         id_mode  = MODE_DOT;
         id_count = 8'd1;
      end else if (is_op) begin
         id_emit = 1'b1;
         id_rsp  = '{token_kind: KIND_OP, op_char: item.ch, lexeme_len: 8'd1, last: 1'b0};
      end else if (item.ch == CH_DOLLAR || item.ch == CH_SEMI) begin
         id_emit = 1'b1;
         id_halt = 1'b1;
         id_rsp  = '{token_kind: KIND_END, op_char: 8'd0, lexeme_len: 8'd1, last: 1'b0};
      end else begin
         id_emit = 1'b1;
         id_halt = 1'b1;
      end
   end

   // Pending token, emitted when its lexeme ends
   always_comb begin
      flush_kind = (mode == MODE_IDENT) ? KIND_ID : KIND_NUM;
      flush_rsp  = '{token_kind: flush_kind, op_char: 8'd0, lexeme_len: count, last: 1'b0};
   end

   // Advance the scanner
   always_comb begin
      step.n_results = 2'd0;
      step.slot0     = flush_rsp;
      step.slot1     = id_rsp;
      step.mode      = mode;
      step.count     = count;
      step.halt      = 1'b0;
      if (item.end_of_input) begin
         step.mode  = MODE_IDLE;
         step.count = 8'd0;
         step.halt  = 1'b1;
         step.slot1 = '{token_kind: KIND_END, op_char: 8'd0, lexeme_len: 8'd0, last: 1'b0};
         case (mode)
            MODE_DOT: begin
               step.n_results = 2'd1;
               step.slot0 = '{token_kind: KIND_ERR, op_char: 8'd0, lexeme_len: 8'd1,
                              last: 1'b0};
            end
            MODE_IDENT, MODE_INT, MODE_FRAC: begin
               step.n_results = 2'd2;
            end
            default: begin
               step.n_results = 2'd1;
               step.slot0 = step.slot1;
            end
         endcase
      end else begin
         case (mode)
            MODE_IDENT: begin
               if (is_alpha || is_digit) begin
                  step.count = bumped;
               end else begin
                  step.n_results = id_emit ? 2'd2 : 2'd1;
                  step.mode      = id_mode;
                  step.count     = id_count;
                  step.halt      = id_halt;
               end
            end
            MODE_INT: begin
               if (is_digit) begin
                  step.count = bumped;
               end else if (item.ch == CH_DOT) begin
                  step.count = bumped;
                  step.mode  = MODE_FRAC;
               end else begin
                  step.n_results = id_emit ? 2'd2 : 2'd1;
                  step.mode      = id_mode;
                  step.count     = id_count;
                  step.halt      = id_halt;
               end
            end
            MODE_FRAC: begin
               if (is_digit) begin
                  step.count = bumped;
               end else begin
                  step.n_results = id_emit ? 2'd2 : 2'd1;
                  step.mode      = id_mode;
                  step.count     = id_count;
                  step.halt      = id_halt;
               end
            end
            MODE_DOT: begin
               if (is_digit) begin
                  step.count = bumped;
                  step.mode  = MODE_FRAC;
               end else begin
                  step.n_results = 2'd1;
                  step.slot0 = '{token_kind: KIND_ERR, op_char: 8'd0, lexeme_len: 8'd1,
                                 last: 1'b0};
                  step.mode  = MODE_IDLE;
                  step.count = 8'd0;
                  step.halt  = 1'b1;
               end
            end
            default: begin
               // idle, and any code that cannot arise
               step.n_results = id_emit ? 2'd1 : 2'd0;
               step.slot0     = id_rsp;
               step.mode      = id_mode;
               step.count     = id_count;
               step.halt      = id_halt;
            end
         endcase
      end
      // Mark the final word of this input
      if (step.n_results == 2'd2) begin
         step.slot1.last = 1'b1;
      end else begin
         step.slot0.last = 1'b1;
      end
   end

endmodule

// ===== sv/ect_rsp_fifo.sv =====
// Result queue: takes up to two words a cycle, hands out one word a cycle
// while the receiver is ready. Depends on ect_pkg.
module ect_rsp_fifo
   import ect_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  rsp_type    push0,
   input  rsp_type    push1,
   output logic [$clog2(RspDepth):0] level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload
);

   localparam int PtrW = $clog2(RspDepth);

   rsp_type             mem_ff [RspDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]       level_ff, level_in;
   logic                pop;

   // Drain one word when the receiver takes it
   always_comb begin
      rsp_valid   = (level_ff != '0);
      pop         = rsp_valid && rsp_ready;
      rsp_payload = mem_ff[rd_ptr_ff];
      level       = level_ff;
      wr_ptr_in   = wr_ptr_ff + PtrW'(push_count);
      rd_ptr_in   = rd_ptr_ff + PtrW'(pop);
      level_in    = level_ff + (PtrW+1)'(push_count) - (PtrW+1)'(pop);
   end

   // Store incoming words
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_ff + PtrW'(1)] <= push1;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

// ===== sv/expression_char_tokenizer_unit.sv =====
// Top level of the expression character tokenizer.
// Depends on ect_pkg, ect_step and ect_rsp_fifo.
//
// Usage: one ASCII character arrives per req_ word (req_payload.ch), or an
// end-of-stream mark (req_payload.end_of_input). Whitespace is skipped and
// each finished identifier, number, operator, end or error token comes out
// as one rsp_ word carrying its kind, operator character and lexeme length;
// rsp_payload.last flags the final word caused by each req_ word.
// Path: a word enters the input register, the scanner step runs on it once the
// result queue has room and writes its words into the queue, from which the
// first result word is offered to the receiver.
// Throughput: one character per cycle while the receiver is ready and each
// character yields at most one word; a character that closes a token and
// also emits an operator, end or error yields two words, and the
// one-word-per-cycle result port then sets the rate. The scanner step fires
// only when the four-entry result queue has room for two words.
// Reset clears the scanner to idle, the queue to empty and the halt flag.
// After an end or error token the block halts: further characters are taken
// and dropped until reset. While the receiver stalls, the queue fills and
// then req_ready falls; no word is lost.
module expression_char_tokenizer_unit
   import ect_pkg::*;
#(
   parameter int MAX_LEXEME_LEN = MaxLexemeLenDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic                     in_valid_ff, in_valid_in;
   req_type                  in_item_ff;
   mode_type                 mode_ff, mode_in;
   logic [7:0]               count_ff, count_in;
   logic                     halted_ff, halted_in;
   step_type                 step;
   logic                     fire;
   logic [1:0]               push_count;
   logic [$clog2(RspDepth):0] level;

   ect_step #(
      .MAX_LEXEME_LEN(MAX_LEXEME_LEN)
   ) u_step (
      .item  (in_item_ff),
      .mode  (mode_ff),
      .count (count_ff),
      .step  (step)
   );

   ect_rsp_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push0       (step.slot0),
      .push1       (step.slot1),
      .level       (level),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Run the step when the queue has room for two words
   always_comb begin
      fire        = in_valid_ff && (level <= ($clog2(RspDepth)+1)'(RspDepth - 2));
      req_ready   = !in_valid_ff || fire;
      in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);
      push_count  = (fire && !halted_ff) ? step.n_results : 2'd0;
      mode_in     = mode_ff;
      count_in    = count_ff;
      halted_in   = halted_ff;
      if (fire && !halted_ff) begin
         mode_in   = step.mode;
         count_in  = step.count;
         halted_in = step.halt;
      end
   end

   // Hold the input word
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
   end

   // Scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         count_ff    <= 8'd0;
         halted_ff   <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         halted_ff   <= halted_in;
      end
   end

   // Queue never overfills
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= ($clog2(RspDepth)+1)'(RspDepth))
      else $error("result queue overfilled");

   // A halting step emits a final end or error word
   a_halt_word: assert property (@(posedge clock) disable iff (reset)
      (fire && !halted_ff && step.halt) |->
         ((step.n_results == 2'd1 && (step.slot0.token_kind == KIND_END ||
                                      step.slot0.token_kind == KIND_ERR)) ||
          (step.n_results == 2'd2 && (step.slot1.token_kind == KIND_END ||
                                      step.slot1.token_kind == KIND_ERR))))
      else $error("halt without end or error token");

   // Halt holds until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

endmodule
